[src/mcl_pkg.sv]
// shared constants, types and helpers for the midi controller learn table
package mcl_pkg;

    localparam int NUM_CELLS  = 16;
    localparam int NUM_VOICES = 16;

    localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CELL_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int BANK_DEPTH = NUM_VOICES * 64;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int PEND_DEPTH = NUM_VOICES * 32;
    localparam int PEND_AW    = $clog2(PEND_DEPTH);

    localparam logic [2:0] OP_MIDI   = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_ARM    = 3'd2;
    localparam logic [2:0] OP_ASSIGN = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;

    localparam logic [1:0] REG_INPUT_CHANNEL = 2'd0;
    localparam logic [1:0] REG_MPE_MODE      = 2'd1;
    localparam logic [1:0] REG_LSB_MODE      = 2'd2;
    localparam logic [1:0] REG_BYPASS        = 2'd3;

    localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
    localparam logic [3:0] KIND_CONTROL  = 4'hB;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    localparam logic signed [7:0] CTL_UNBOUND = -8'sd1;
    localparam logic [13:0]       BEND_CENTER = 14'd8192;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [PEND_AW-1:0] paddr;
    } mem_rd_t;

    typedef struct packed {
        logic               b0_we;
        logic               b1_we;
        logic [BANK_AW-1:0] addr;
        logic [6:0]         b0_data;
        logic [6:0]         b1_data;
        logic               p_we;
        logic [PEND_AW-1:0] paddr;
        logic [6:0]         p_data;
    } mem_wr_t;

    typedef struct packed {
        logic [6:0] b0;
        logic [6:0] b1;
        logic [6:0] pend;
    } mem_rdata_t;

    // bank holds controllers by bit 5, so c and c+32 sit at the same address
    function automatic logic [BANK_AW-1:0] bank_addr(logic [VOICE_W-1:0] v, logic [6:0] c);
        return BANK_AW'({v, c[6], c[4:0]});
    endfunction

    function automatic logic [PEND_AW-1:0] pend_addr(logic [VOICE_W-1:0] v, logic [6:0] c);
        return PEND_AW'({v, c[4:0]});
    endfunction

    function automatic logic [VOICE_W-1:0] read_voice(logic [3:0] voice, logic mpe);
        logic [4:0] v;
        v = mpe ? {1'b0, voice} : 5'd0;
        if (v >= 5'(NUM_VOICES))
            v = 5'(NUM_VOICES - 1);
        return VOICE_W'(v);
    endfunction

endpackage

[src/mcl_ctl_mem.sv]
// controller value banks and pending msb memory with clearing pass and write forwarding
module mcl_ctl_mem (
    input  logic                clk,
    input  logic                rst_n,
    input  mcl_pkg::mem_rd_t    rd,
    input  mcl_pkg::mem_wr_t    wr,
    output mcl_pkg::mem_rdata_t rdata,
    output logic                busy
);
    import mcl_pkg::*;

    logic [6:0] bank0 [BANK_DEPTH];
    logic [6:0] bank1 [BANK_DEPTH];
    logic [6:0] pend  [PEND_DEPTH];

    logic               clearing_reg;
    logic [BANK_AW-1:0] clr_cnt_reg;

    logic               we0, we1, wep;
    logic [BANK_AW-1:0] waddr;
    logic [PEND_AW-1:0] wpaddr;
    logic [6:0]         wd0, wd1, wdp;

    logic [6:0] q0_reg, q1_reg, qp_reg;
    logic [6:0] f0_reg, f1_reg, fp_reg;
    logic       hit0_reg, hit1_reg, hitp_reg;

    assign busy = clearing_reg;

    always_comb
    begin
        if (clearing_reg)
        begin
            we0    = 1'b1;
            we1    = 1'b1;
            wep    = 1'b1;
            waddr  = clr_cnt_reg;
            wpaddr = PEND_AW'(clr_cnt_reg);
            wd0    = 7'd0;
            wd1    = 7'd0;
            wdp    = 7'd0;
        end
        else
        begin
            we0    = wr.b0_we;
            we1    = wr.b1_we;
            wep    = wr.p_we;
            waddr  = wr.addr;
            wpaddr = wr.paddr;
            wd0    = wr.b0_data;
            wd1    = wr.b1_data;
            wdp    = wr.p_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == BANK_AW'(BANK_DEPTH - 1))
                clearing_reg <= 1'b0;
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
            bank0[waddr] <= wd0;
        if (we1)
            bank1[waddr] <= wd1;
        if (wep)
            pend[wpaddr] <= wdp;
    end

    // a write on the same edge as the read is caught here, memory gives old data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            q0_reg   <= bank0[rd.addr];
            q1_reg   <= bank1[rd.addr];
            qp_reg   <= pend[rd.paddr];
            hit0_reg <= we0 && (waddr == rd.addr);
            hit1_reg <= we1 && (waddr == rd.addr);
            hitp_reg <= wep && (wpaddr == rd.paddr);
            f0_reg   <= wd0;
            f1_reg   <= wd1;
            fp_reg   <= wdp;
        end
    end

    assign rdata.b0   = hit0_reg ? f0_reg : q0_reg;
    assign rdata.b1   = hit1_reg ? f1_reg : q1_reg;
    assign rdata.pend = hitp_reg ? fp_reg : qp_reg;

endmodule

[src/midi_cc_learn_table.sv]
// reads pass stage one, then the output register; out_valid rises once the result slot is free
// throughput: one request per cycle while results are taken; one stage plus an output register
// the memory read for a request happens at its accept edge, its updates land in the following cycle
// reset: a clearing pass runs over the controller memories, in_ready stays low
// configuration writes are taken during the clearing pass; small tables reset in flops
module midi_cc_learn_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [4:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [7:0]        status_byte,
    input  logic [6:0]        data_first,
    input  logic [6:0]        data_second,
    input  logic [4:0]        cell_req,
    input  logic [3:0]        voice,
    input  logic signed [7:0] assign_controller,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [13:0]       cell_value,
    output logic              unassigned,
    output logic signed [7:0] bound_controller
);
    import mcl_pkg::*;

    // configuration
    logic [4:0] input_channel_reg;
    logic       mpe_mode_reg, lsb_mode_reg, bypass_reg;

    // stage one request
    logic              s1_valid_reg;
    logic [2:0]        s1_op_reg;
    logic [7:0]        s1_status_reg;
    logic [6:0]        s1_d1_reg, s1_d2_reg;
    logic [4:0]        s1_cell_reg;
    logic [3:0]        s1_voice_reg;
    logic signed [7:0] s1_ac_reg;

    // tables and learn state
    logic [6:0]        pressure_reg [NUM_VOICES];
    logic [13:0]       bend_reg     [NUM_VOICES];
    logic signed [7:0] bind_reg     [NUM_CELLS];
    logic signed [7:0] bind_next    [NUM_CELLS];
    logic              learn_armed_reg, learn_armed_next;
    logic [CELL_W-1:0] learn_cell_reg, learn_cell_next;

    // result register
    logic              out_valid_reg;
    logic [13:0]       cell_value_reg;
    logic              unassigned_reg;
    logic signed [7:0] bound_reg;

    mem_rd_t    mrd;
    mem_wr_t    mwr;
    mem_rdata_t mdat;
    logic       mem_busy;

    logic s1_fire, in_accept;

    mcl_ctl_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (mrd),
        .wr    (mwr),
        .rdata (mdat),
        .busy  (mem_busy)
    );

    assign s1_fire   = s1_valid_reg && ((s1_op_reg != OP_READ) || !out_valid_reg || out_ready);
    assign in_ready  = !mem_busy && (!s1_valid_reg || s1_fire);
    assign in_accept = in_valid && in_ready;

    // stage one decode
    logic [3:0]         kind, chan;
    logic               msg_ok, chan_in_range, cc_go, learn_hit;
    logic [VOICE_W-1:0] wv, rv;
    logic [6:0]         cur_val;
    logic               lsb_lo, lsb_hi;
    logic               s1_cell_ok;
    logic [CELL_W-1:0]  s1_cell_idx;
    logic               do_bind;
    logic [CELL_W-1:0]  bind_cell;
    logic signed [7:0]  bind_ctl;

    assign kind          = s1_status_reg[7:4];
    assign chan          = s1_status_reg[3:0];
    assign chan_in_range = {1'b0, chan} < 5'(NUM_VOICES);
    assign msg_ok        = s1_fire && (s1_op_reg == OP_MIDI) && !bypass_reg
                           && ((input_channel_reg == 5'd0) || (s1_status_reg >= STATUS_SYSTEM)
                               || (({1'b0, chan} + 5'd1) == input_channel_reg));
    assign cc_go         = msg_ok && (kind == KIND_CONTROL) && (!mpe_mode_reg || chan_in_range);
    assign wv            = mpe_mode_reg ? VOICE_W'(chan) : '0;
    assign rv            = read_voice(s1_voice_reg, mpe_mode_reg);
    assign cur_val       = s1_d1_reg[5] ? mdat.b1 : mdat.b0;
    assign learn_hit     = cc_go && learn_armed_reg && (cur_val != s1_d2_reg);
    assign lsb_lo        = lsb_mode_reg && (s1_d1_reg[6:5] == 2'b00);
    assign lsb_hi        = lsb_mode_reg && (s1_d1_reg[6:5] == 2'b01);
    assign s1_cell_ok    = {1'b0, s1_cell_reg} < 6'(NUM_CELLS);
    assign s1_cell_idx   = CELL_W'(s1_cell_reg);

    // memory writes for a controller change
    always_comb
    begin
        mwr.addr    = bank_addr(wv, s1_d1_reg);
        mwr.paddr   = pend_addr(wv, s1_d1_reg);
        mwr.p_data  = s1_d2_reg;
        mwr.p_we    = cc_go && lsb_lo;
        mwr.b0_we   = 1'b0;
        mwr.b1_we   = 1'b0;
        mwr.b0_data = s1_d2_reg;
        mwr.b1_data = s1_d2_reg;
        if (cc_go && lsb_hi)
        begin
            // lsb arrives: commit held msb and the lsb together
            mwr.b0_we   = 1'b1;
            mwr.b1_we   = 1'b1;
            mwr.b0_data = mdat.pend;
        end
        else if (cc_go && !lsb_lo)
        begin
            mwr.b0_we = !s1_d1_reg[5];
            mwr.b1_we = s1_d1_reg[5];
        end
    end

    // binding and learn updates
    always_comb
    begin
        do_bind          = 1'b0;
        bind_cell        = learn_cell_reg;
        bind_ctl         = $signed({1'b0, s1_d1_reg});
        learn_armed_next = learn_armed_reg;
        learn_cell_next  = learn_cell_reg;
        if (learn_hit)
        begin
            do_bind          = 1'b1;
            learn_armed_next = 1'b0;
        end
        else if (s1_fire && (s1_op_reg == OP_ARM) && s1_cell_ok)
        begin
            learn_armed_next = 1'b1;
            learn_cell_next  = s1_cell_idx;
        end
        else if (s1_fire && (s1_op_reg == OP_ASSIGN) && s1_cell_ok)
        begin
            do_bind   = 1'b1;
            bind_cell = s1_cell_idx;
            bind_ctl  = s1_ac_reg[7] ? CTL_UNBOUND : s1_ac_reg;
        end
        else if (s1_fire && (s1_op_reg == OP_CANCEL))
        begin
            learn_armed_next = 1'b0;
        end
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            bind_next[i] = bind_reg[i];
            if (do_bind && !bind_ctl[7] && (bind_reg[i] == bind_ctl))
                bind_next[i] = CTL_UNBOUND;
            if (do_bind && (CELL_W'(i) == bind_cell))
                bind_next[i] = bind_ctl;
        end
    end

    // read address from the incoming request, using bindings after stage one lands
    logic               in_cell_ok;
    logic [VOICE_W-1:0] in_v;
    logic [6:0]         in_c;

    always_comb
    begin
        in_cell_ok = {1'b0, cell_req} < 6'(NUM_CELLS);
        if (operation == OP_READ)
        begin
            in_v = read_voice(voice, mpe_mode_reg);
            in_c = in_cell_ok ? bind_next[CELL_W'(cell_req)][6:0] : 7'd0;
        end
        else
        begin
            in_v = mpe_mode_reg ? VOICE_W'(status_byte[3:0]) : '0;
            in_c = data_first;
        end
        mrd.en    = in_accept;
        mrd.addr  = bank_addr(in_v, in_c);
        mrd.paddr = pend_addr(in_v, in_c);
    end

    // read result
    logic [13:0]       res_value;
    logic              res_unas;
    logic signed [7:0] res_bound;
    logic signed [7:0] rb;
    logic [6:0]        rhi, rlo;

    always_comb
    begin
        rb        = bind_reg[s1_cell_idx];
        rhi       = rb[5] ? mdat.b1 : mdat.b0;
        rlo       = (lsb_mode_reg && (rb[6:5] == 2'b00)) ? mdat.b1 : 7'd0;
        res_value = 14'd0;
        res_unas  = 1'b1;
        res_bound = CTL_UNBOUND;
        if (s1_cell_ok)
        begin
            if (!rb[7])
            begin
                res_value = {rhi, 7'd0} | {7'd0, rlo};
                res_unas  = 1'b0;
                res_bound = rb;
            end
        end
        else if ({1'b0, s1_cell_reg} == 6'(NUM_CELLS))
        begin
            res_value = {7'd0, pressure_reg[rv]};
            res_unas  = 1'b0;
        end
        else if ({1'b0, s1_cell_reg} == 6'(NUM_CELLS + 1))
        begin
            res_value = bend_reg[rv];
            res_unas  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_channel_reg <= 5'd0;
            mpe_mode_reg      <= 1'b0;
            lsb_mode_reg      <= 1'b0;
            bypass_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INPUT_CHANNEL: input_channel_reg <= cfg_data;
                REG_MPE_MODE:      mpe_mode_reg      <= cfg_data[0];
                REG_LSB_MODE:      lsb_mode_reg      <= cfg_data[0];
                REG_BYPASS:        bypass_reg        <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            learn_armed_reg <= 1'b0;
            learn_cell_reg  <= '0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                pressure_reg[i] <= 7'd0;
                bend_reg[i]     <= BEND_CENTER;
            end
            for (int i = 0; i < NUM_CELLS; i++)
                bind_reg[i] <= 8'(i + 1);
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire && (s1_op_reg == OP_READ))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            learn_armed_reg <= learn_armed_next;
            learn_cell_reg  <= learn_cell_next;
            for (int i = 0; i < NUM_CELLS; i++)
                bind_reg[i] <= bind_next[i];

            if (msg_ok && (kind == KIND_PRESSURE) && chan_in_range)
                pressure_reg[VOICE_W'(chan)] <= s1_d1_reg;
            if (msg_ok && (kind == KIND_BEND) && chan_in_range)
                bend_reg[VOICE_W'(chan)] <= {s1_d2_reg, s1_d1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= operation;
            s1_status_reg <= status_byte;
            s1_d1_reg     <= data_first;
            s1_d2_reg     <= data_second;
            s1_cell_reg   <= cell_req;
            s1_voice_reg  <= voice;
            s1_ac_reg     <= assign_controller;
        end
        if (s1_fire && (s1_op_reg == OP_READ))
        begin
            cell_value_reg <= res_value;
            unassigned_reg <= res_unas;
            bound_reg      <= res_bound;
        end
    end

    assign out_valid        = out_valid_reg;
    assign cell_value       = cell_value_reg;
    assign unassigned       = unassigned_reg;
    assign bound_controller = bound_reg;

    a_no_accept_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !in_ready)
        else $error("request accepted during clearing pass");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_op_reg) && $stable(s1_cell_reg))
        else $error("stalled request lost");

    a_learn_disarms : assert property (@(posedge clk) disable iff (!rst_n)
        learn_hit |=> !learn_armed_reg)
        else $error("learn still armed after binding");

    a_learn_binds : assert property (@(posedge clk) disable iff (!rst_n)
        learn_hit |=> bind_reg[$past(learn_cell_reg)] == $signed({1'b0, $past(s1_d1_reg)}))
        else $error("learned controller not bound to armed cell");

    a_result_slot : assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_op_reg == OP_READ) |-> !out_valid_reg || out_ready)
        else $error("read result overwrote pending result");

endmodule

[test/midi_cc_learn_table_check.sv]
`timescale 1ns / 1ps
// checker for midi_cc_learn_table: mirrors the controller tables and compares every read result
module midi_cc_learn_table_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [4:0]        cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [7:0]        status_byte,
    input  logic [6:0]        data_first,
    input  logic [6:0]        data_second,
    input  logic [4:0]        cell_req,
    input  logic [3:0]        voice,
    input  logic signed [7:0] assign_controller,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [13:0]       cell_value,
    input  logic              unassigned,
    input  logic signed [7:0] bound_controller,
    output int                errors,
    output int                pending
);
    import mcl_pkg::*;

    typedef struct packed {
        logic [13:0]       value;
        logic              unas;
        logic signed [7:0] bound;
    } cell_read_t;

    logic [6:0]        ctl_val   [128][NUM_VOICES];
    logic [6:0]        msb_hold  [32][NUM_VOICES];
    logic [6:0]        press_val [NUM_VOICES];
    logic [13:0]       bend_val  [NUM_VOICES];
    logic signed [7:0] binding   [NUM_CELLS];
    logic              armed;
    logic [CELL_W-1:0] armed_cell;

    logic [4:0]        chan_sel;
    logic              mpe_on;
    logic              pair_on;
    logic              drop_all;

    cell_read_t        expected_reads [$];

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // a controller bound to one cell is taken away from every other cell
    function automatic void bind_ctl(int cell_idx, logic signed [7:0] ctl);
        if (ctl >= 0)
        begin
            for (int i = 0; i < NUM_CELLS; i++)
                if (binding[i] == ctl)
                    binding[i] = CTL_UNBOUND;
        end
        if (cell_idx < NUM_CELLS)
            binding[cell_idx] = ctl;
    endfunction

    task automatic mirror_request();
        logic [3:0]         ch;
        logic [VOICE_W-1:0] v;
        logic [6:0]         c;
        cell_read_t         r;

        ch = status_byte[3:0];
        case (operation)
            OP_MIDI:
            begin
                if (!drop_all && (chan_sel == 0 || status_byte >= STATUS_SYSTEM
                                  || {1'b0, ch} + 5'd1 == chan_sel))
                begin
                    if (status_byte[7:4] == KIND_PRESSURE)
                        press_val[ch] = data_first;
                    else if (status_byte[7:4] == KIND_BEND)
                        bend_val[ch] = {data_second, data_first};
                    else if (status_byte[7:4] == KIND_CONTROL)
                    begin
                        v = mpe_on ? ch : '0;
                        // learning fires only on a real change of the committed value
                        if (armed && ctl_val[data_first][v] != data_second)
                        begin
                            bind_ctl(armed_cell, {1'b0, data_first});
                            armed = 1'b0;
                        end
                        if (pair_on && data_first < 7'd32)
                            msb_hold[data_first[4:0]][v] = data_second;
                        else if (pair_on && data_first < 7'd64)
                        begin
                            ctl_val[{2'b00, data_first[4:0]}][v] = msb_hold[data_first[4:0]][v];
                            ctl_val[data_first][v] = data_second;
                        end
                        else
                            ctl_val[data_first][v] = data_second;
                    end
                end
            end
            OP_READ:
            begin
                r.value = '0;
                r.unas  = 1'b1;
                r.bound = CTL_UNBOUND;
                v = mpe_on ? voice : '0;
                if (cell_req < NUM_CELLS)
                begin
                    if (binding[cell_req] >= 0)
                    begin
                        c = binding[cell_req][6:0];
                        r.value = {ctl_val[c][v], 7'd0};
                        if (pair_on && c < 7'd32)
                            r.value = r.value + ctl_val[c + 7'd32][v];
                        r.unas  = 1'b0;
                        r.bound = binding[cell_req];
                    end
                end
                else if (cell_req == NUM_CELLS)
                begin
                    r.value = press_val[v];
                    r.unas  = 1'b0;
                end
                else if (cell_req == NUM_CELLS + 1)
                begin
                    r.value = bend_val[v];
                    r.unas  = 1'b0;
                end
                expected_reads.push_back(r);
            end
            OP_ARM:
            begin
                if (cell_req < NUM_CELLS)
                begin
                    armed      = 1'b1;
                    armed_cell = cell_req[CELL_W-1:0];
                end
            end
            OP_ASSIGN:
            begin
                if (cell_req < NUM_CELLS)
                    bind_ctl(cell_req, assign_controller[7] ? CTL_UNBOUND : assign_controller);
            end
            OP_CANCEL:
                armed = 1'b0;
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 128; c++)
                for (int v = 0; v < NUM_VOICES; v++)
                    ctl_val[c][v] = '0;
            for (int c = 0; c < 32; c++)
                for (int v = 0; v < NUM_VOICES; v++)
                    msb_hold[c][v] = '0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                press_val[v] = '0;
                bend_val[v]  = BEND_CENTER;
            end
            for (int i = 0; i < NUM_CELLS; i++)
                binding[i] = 8'(i + 1);
            armed      = 1'b0;
            armed_cell = '0;
            chan_sel   = '0;
            mpe_on     = 1'b0;
            pair_on    = 1'b0;
            drop_all   = 1'b0;
            expected_reads.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INPUT_CHANNEL: chan_sel = cfg_data;
                    REG_MPE_MODE:      mpe_on   = cfg_data[0];
                    REG_LSB_MODE:      pair_on  = cfg_data[0];
                    REG_BYPASS:        drop_all = cfg_data[0];
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
                mirror_request();
            if (out_valid && out_ready)
            begin
                if (expected_reads.size() == 0)
                    report_mismatch("result with no read request waiting, cell_value",
                                    cell_value, 0);
                else
                begin
                    cell_read_t want;
                    want = expected_reads.pop_front();
                    if (cell_value !== want.value)
                        report_mismatch("cell_value", cell_value, want.value);
                    if (unassigned !== want.unas)
                        report_mismatch("unassigned", unassigned, want.unas);
                    if (bound_controller !== want.bound)
                        report_mismatch("bound_controller", bound_controller, want.bound);
                end
            end
            pending = expected_reads.size();
        end
    end

endmodule

[test/midi_cc_learn_table_test.sv]
`timescale 1ns / 1ps
// stimulus, watchdog and verdict for midi_cc_learn_table
module midi_cc_learn_table_test;
    import mcl_pkg::*;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 140;
    localparam int NUM_PHASES  = 8;

    localparam logic [2:0] OP_SPARE_LO    = 3'd5;
    localparam logic [2:0] OP_SPARE_HI    = 3'd7;
    localparam logic [7:0] STATUS_NOTE_ON = 8'h90;

    typedef struct packed {
        logic [2:0]        op;
        logic [7:0]        st;
        logic [6:0]        d1;
        logic [6:0]        d2;
        logic [4:0]        cell_num;
        logic [3:0]        voice;
        logic signed [7:0] ac;
    } midi_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [4:0]        cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        operation = '0;
    logic [7:0]        status_byte = '0;
    logic [6:0]        data_first = '0;
    logic [6:0]        data_second = '0;
    logic [4:0]        cell_req = '0;
    logic [3:0]        voice = '0;
    logic signed [7:0] assign_controller = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [13:0]       cell_value;
    logic              unassigned;
    logic signed [7:0] bound_controller;

    int                errors;
    int                pending;

    logic              steady = 1'b0;
    logic [4:0]        cur_chan = '0;
    int                sent = 0;
    int                stall_cycles = 0;

    midi_cc_learn_table dut (.*);

    midi_cc_learn_table_check table_check (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("midi_cc_learn_table test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // mostly the filtered channel or a few low ones, so the voices see repeated traffic
    function automatic logic [3:0] pick_chan();
        if (cur_chan != 0 && cur_chan <= 5'd16 && $urandom_range(99) < 75)
            return 4'(cur_chan - 5'd1);
        if ($urandom_range(99) < 70)
            return 4'($urandom_range(3));
        return 4'($urandom);
    endfunction

    // controllers near the reset bindings and their lsb partners
    function automatic logic [6:0] pick_ctl();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 7'($urandom_range(17));
        if (roll < 75)
            return 7'($urandom_range(49, 32));
        return 7'($urandom);
    endfunction

    task automatic send(midi_req_t r);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation         <= r.op;
        status_byte       <= r.st;
        data_first        <= r.d1;
        data_second       <= r.d2;
        cell_req          <= r.cell_num;
        voice             <= r.voice;
        assign_controller <= r.ac;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_op(logic [2:0] op, logic [4:0] cell_sel, logic signed [7:0] ac);
        midi_req_t r;
        r.op       = op;
        r.st       = 8'($urandom);
        r.d1       = 7'($urandom);
        r.d2       = 7'($urandom);
        r.cell_num = cell_sel;
        r.voice    = pick_chan();
        r.ac       = ac;
        send(r);
    endtask

    task automatic send_midi(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        midi_req_t r;
        r.op       = OP_MIDI;
        r.st       = st;
        r.d1       = d1;
        r.d2       = d2;
        r.cell_num = 5'($urandom);
        r.voice    = 4'($urandom);
        r.ac       = 8'($urandom);
        send(r);
    endtask

    // waits out every outstanding read and the table update behind the last request
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [4:0] chan, logic mpe, logic lsb, logic byp);
        cfg_write <= 1'b1;
        cfg_index <= REG_INPUT_CHANNEL;
        cfg_data  <= chan;
        @(posedge clk);
        cfg_index <= REG_MPE_MODE;
        cfg_data  <= {4'($urandom), mpe};
        @(posedge clk);
        cfg_index <= REG_LSB_MODE;
        cfg_data  <= {4'($urandom), lsb};
        @(posedge clk);
        cfg_index <= REG_BYPASS;
        cfg_data  <= {4'($urandom), byp};
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_chan = chan;
    endtask

    task automatic random_phase(int count);
        int         target;
        int         roll;
        logic [3:0] ch;
        logic [4:0] cell_sel;
        logic [6:0] num;

        target = sent + count;
        while (sent < target)
        begin
            roll = $urandom_range(99);
            ch   = pick_chan();
            if (roll < 30)
                send_midi({KIND_CONTROL, ch}, pick_ctl(),
                          ($urandom_range(99) < 15) ? 7'd0 : 7'($urandom));
            else if (roll < 40)
            begin
                // 14-bit pair: msb request, then its lsb partner on the same channel
                num = 7'($urandom_range(31));
                send_midi({KIND_CONTROL, ch}, num, 7'($urandom));
                send_midi({KIND_CONTROL, ch}, num + 7'd32, 7'($urandom));
            end
            else if (roll < 48)
                send_midi({($urandom_range(1) != 0) ? KIND_PRESSURE : KIND_BEND, ch},
                          7'($urandom), 7'($urandom));
            else if (roll < 53)
                send_midi(8'($urandom), 7'($urandom), 7'($urandom));
            else if (roll < 75)
            begin
                if ($urandom_range(99) < 85)
                    cell_sel = 5'($urandom_range(NUM_CELLS + 1));
                else
                    cell_sel = 5'($urandom_range(31, NUM_CELLS + 2));
                send_op(OP_READ, cell_sel, 8'($urandom));
            end
            else if (roll < 83)
            begin
                // learn: arm, move a controller, read the cell back
                if ($urandom_range(99) < 90)
                    cell_sel = 5'($urandom_range(NUM_CELLS - 1));
                else
                    cell_sel = 5'($urandom_range(31, NUM_CELLS));
                send_op(OP_ARM, cell_sel, 8'($urandom));
                send_midi({KIND_CONTROL, ch}, pick_ctl(), 7'($urandom));
                send_op(OP_READ, cell_sel, 8'($urandom));
            end
            else if (roll < 91)
            begin
                if ($urandom_range(99) < 90)
                    cell_sel = 5'($urandom_range(NUM_CELLS - 1));
                else
                    cell_sel = 5'($urandom_range(31, NUM_CELLS));
                if ($urandom_range(99) < 25)
                    send_op(OP_ASSIGN, cell_sel, {1'b1, 7'($urandom)});
                else
                    send_op(OP_ASSIGN, cell_sel, {1'b0, pick_ctl()});
            end
            else if (roll < 96)
                send_op(OP_CANCEL, 5'($urandom), 8'($urandom));
            else
                send_op(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 5'($urandom),
                        8'($urandom));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_config(5'd0, 1'b0, 1'b0, 1'b0);

        // defaults, extremes and the special cases in folded mode
        send_op(OP_READ, 5'd0, 8'sd0);
        send_op(OP_READ, 5'(NUM_CELLS), 8'sd0);
        send_op(OP_READ, 5'(NUM_CELLS + 1), 8'sd0);
        send_op(OP_READ, 5'd31, 8'sd0);
        send_midi({KIND_CONTROL, 4'hF}, 7'd1, 7'd127);
        send_op(OP_READ, 5'd0, 8'sd0);
        send_midi({KIND_PRESSURE, 4'h0}, 7'd127, 7'd0);
        send_midi({KIND_BEND, 4'h0}, 7'd127, 7'd127);
        send_op(OP_READ, 5'(NUM_CELLS), 8'sd0);
        send_op(OP_READ, 5'(NUM_CELLS + 1), 8'sd0);
        send_midi({STATUS_SYSTEM[7:4], 4'h7}, 7'd1, 7'd0);
        send_midi(STATUS_NOTE_ON, 7'd1, 7'd0);
        send_op(OP_ARM, 5'd3, 8'sd0);
        send_midi({KIND_CONTROL, 4'h0}, 7'd1, 7'd127);
        send_midi({KIND_CONTROL, 4'h0}, 7'd77, 7'd5);
        send_op(OP_READ, 5'd3, 8'sd0);
        send_op(OP_ARM, 5'd20, 8'sd0);
        send_op(OP_ARM, 5'd0, 8'sd0);
        send_op(OP_CANCEL, 5'd0, 8'sd0);
        send_midi({KIND_CONTROL, 4'h0}, 7'd2, 7'd9);
        send_op(OP_ASSIGN, 5'd5, -8'sd128);
        send_op(OP_READ, 5'd5, 8'sd0);
        send_op(OP_ASSIGN, 5'd6, 8'sd1);
        send_op(OP_READ, 5'd0, 8'sd0);
        send_op(OP_ASSIGN, 5'(NUM_CELLS), 8'sd7);
        send_op(OP_SPARE_HI, 5'd6, 8'sd0);
        send_op(OP_READ, 5'd6, 8'sd0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0: set_config(5'd0, 1'b0, 1'b0, 1'b0);
                1: set_config(5'd0, 1'b1, 1'b1, 1'b0);
                2: set_config(5'd16, 1'b1, 1'b0, 1'b0);
                3: set_config(5'd1, 1'b0, 1'b1, 1'b0);
                4: set_config(5'd31, 1'b0, 1'b1, 1'b0);
                5: set_config(5'd0, 1'b1, 1'b1, 1'b1);
                default: set_config(5'($urandom_range(17)), 1'($urandom), 1'($urandom),
                                    $urandom_range(99) < 10);
            endcase
            // one phase runs back to back with no idling on either side
            steady <= (phase == 3);
            random_phase(PHASE_ITEMS);
        end
        steady <= 1'b0;
        drain();

        if (errors == 0)
            $display("midi_cc_learn_table test passed");
        else
            $display("midi_cc_learn_table test failed");
        $finish;
    end

endmodule

[filelist.f]
src/mcl_pkg.sv
src/mcl_ctl_mem.sv
src/midi_cc_learn_table.sv
test/midi_cc_learn_table_check.sv
test/midi_cc_learn_table_test.sv
